>>> rtl/core/ssae_pkg.sv
// Shared types, codes and constants for the small set algebra engine.
package ssae_pkg;

  localparam int SET_SIZE_DEF = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int KW           = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD_A  = 2'd0,
    OP_ADD_B  = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ELEMENT    = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_INCOMPLETE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    LS_A     = 3'd0,
    LS_B     = 3'd1,
    LS_UNION = 3'd2,
    LS_INTER = 3'd3,
    LS_AMB   = 3'd4,
    LS_BMA   = 3'd5,
    LS_XOR   = 3'd6
  } lsel_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DUP  = 4'b0010,
    S_INS  = 4'b0100,
    S_MRG  = 4'b1000
  } state_t;

  function automatic logic selected(input logic [2:0] sel, input logic in_a,
                                    input logic in_b);
    logic r;
    case (sel)
      LS_A:     r = in_a;
      LS_B:     r = in_b;
      LS_UNION: r = in_a | in_b;
      LS_INTER: r = in_a & in_b;
      LS_AMB:   r = in_a & ~in_b;
      LS_BMA:   r = in_b & ~in_a;
      LS_XOR:   r = in_a ^ in_b;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/small_set_algebra_engine.sv
// Small set algebra engine: two sorted sets in memories, add, clear and merge report.
// Add writes directly into an empty set; otherwise it runs a duplicate scan and then an
// insertion shift, one memory entry per cycle; a full set ends after the duplicate scan.
// Report returns incomplete from idle if a set is not full, else it runs a merge walk.
// Clear empties both sets from idle. One word in flight; the next is taken as its final result leaves.
// Synchronous reset empties both sets; memory contents are not cleared.
module small_set_algebra_engine #(
  parameter int SET_SIZE = ssae_pkg::SET_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] value,
  input  logic [2:0]         list_select,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] element,
  output logic [3:0]         position,
  output logic               last
);

  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CW = $clog2(SET_SIZE + 1);
  localparam logic [CW-1:0] FULL = CW'(SET_SIZE);
  localparam int KW = ssae_pkg::KW;

  logic [31:0] mem_a [SET_SIZE];
  logic [31:0] mem_b [SET_SIZE];
  logic [31:0] a_q, b_q;

  ssae_pkg::state_t state, state_next;
  logic [CW-1:0] ca, ca_next, cb, cb_next;
  logic [CW-1:0] ix, ix_next, ib, ib_next;
  logic [KW-1:0] k, k_next;
  logic [31:0]   key, key_next;
  logic [2:0]    sel, sel_next;
  logic          tgt, tgt_next;
  logic          pend, pend_next;
  logic [31:0]   pend_key, pend_key_next;
  logic [3:0]    pend_pos, pend_pos_next;

  logic          strobe_next, last_next;
  logic [2:0]    status_next;
  logic [31:0]   element_next;
  logic [3:0]    position_next;

  logic [CW-1:0] rd_a, rd_b, wa;
  logic          we, wt;
  logic [31:0]   wd;

  logic [31:0]   d;
  logic [CW-1:0] n;
  logic          ha, hb, take_a, take_b, hit;
  logic [31:0]   mkey;

  assign busy = (state != ssae_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (we && !wt) mem_a[wa[IW-1:0]] <= wd;
    if (we && wt)  mem_b[wa[IW-1:0]] <= wd;
    a_q <= mem_a[rd_a[IW-1:0]];
    b_q <= mem_b[rd_b[IW-1:0]];
  end

  always_comb begin
    state_next    = state;
    ca_next       = ca;
    cb_next       = cb;
    ix_next       = ix;
    ib_next       = ib;
    k_next        = k;
    key_next      = key;
    sel_next      = sel;
    tgt_next      = tgt;
    pend_next     = pend;
    pend_key_next = pend_key;
    pend_pos_next = pend_pos;
    strobe_next   = 1'b0;
    last_next     = 1'b1;
    status_next   = ssae_pkg::ST_ACCEPTED;
    element_next  = '0;
    position_next = '0;
    rd_a = '0;
    rd_b = '0;
    we   = 1'b0;
    wt   = tgt;
    wa   = ix;
    wd   = key;
    d    = tgt ? b_q : a_q;
    n    = tgt ? cb : ca;
    ha   = (ix < FULL);
    hb   = (ib < FULL);
    take_a = !hb || (ha && (a_q < b_q));
    take_b = !take_a && (!ha || (b_q < a_q));
    mkey   = take_b ? b_q : a_q;
    hit    = ssae_pkg::selected(sel, !take_b, !take_a);

    unique case (state)
      ssae_pkg::S_IDLE: begin
        if (start) begin
          key_next = value ^ ssae_pkg::SIGN_BIAS;
          sel_next = list_select;
          tgt_next = (opcode == ssae_pkg::OP_ADD_B);
          unique case (opcode)
            ssae_pkg::OP_ADD_A, ssae_pkg::OP_ADD_B: begin
              n = tgt_next ? cb : ca;
              if (n == '0) begin
                wt   = tgt_next;
                we   = 1'b1;
                wa   = '0;
                wd   = key_next;
                if (tgt_next) cb_next = CW'(1);
                else ca_next = CW'(1);
                strobe_next = 1'b1;
              end else begin
                ix_next    = '0;
                state_next = ssae_pkg::S_DUP;
              end
            end
            ssae_pkg::OP_REPORT: begin
              if (ca != FULL || cb != FULL) begin
                strobe_next = 1'b1;
                status_next = ssae_pkg::ST_INCOMPLETE;
              end else begin
                ix_next    = '0;
                ib_next    = '0;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ssae_pkg::S_MRG;
              end
            end
            ssae_pkg::OP_CLEAR: begin
              ca_next     = '0;
              cb_next     = '0;
              strobe_next = 1'b1;
            end
          endcase
        end
      end
      ssae_pkg::S_DUP: begin
        if (d == key) begin
          strobe_next = 1'b1;
          status_next = ssae_pkg::ST_DUPLICATE;
          state_next  = ssae_pkg::S_IDLE;
        end else if (ix == n - CW'(1)) begin
          if (n == FULL) begin
            strobe_next = 1'b1;
            status_next = ssae_pkg::ST_FULL;
            state_next  = ssae_pkg::S_IDLE;
          end else begin
            ix_next    = n;
            rd_a       = n - CW'(1);
            rd_b       = n - CW'(1);
            state_next = ssae_pkg::S_INS;
          end
        end else begin
          ix_next = ix + CW'(1);
          rd_a    = ix + CW'(1);
          rd_b    = ix + CW'(1);
        end
      end
      ssae_pkg::S_INS: begin
        we = 1'b1;
        if (ix == '0 || d <= key) begin
          wd = key;
          if (tgt) cb_next = cb + CW'(1);
          else ca_next = ca + CW'(1);
          strobe_next = 1'b1;
          state_next  = ssae_pkg::S_IDLE;
        end else begin
          wd      = d;
          ix_next = ix - CW'(1);
          rd_a    = ix - CW'(2);
          rd_b    = ix - CW'(2);
        end
      end
      ssae_pkg::S_MRG: begin
        if ((!ha && !hb) || k == KW'(ssae_pkg::MAX_RESULTS)) begin
          strobe_next = 1'b1;
          state_next  = ssae_pkg::S_IDLE;
          if (pend) begin
            status_next   = ssae_pkg::ST_ELEMENT;
            element_next  = pend_key ^ ssae_pkg::SIGN_BIAS;
            position_next = pend_pos;
          end else begin
            status_next = ssae_pkg::ST_EMPTY;
          end
        end else begin
          if (!take_b) ix_next = ix + CW'(1);
          if (!take_a) ib_next = ib + CW'(1);
          if (hit) begin
            if (pend) begin
              strobe_next   = 1'b1;
              last_next     = 1'b0;
              status_next   = ssae_pkg::ST_ELEMENT;
              element_next  = pend_key ^ ssae_pkg::SIGN_BIAS;
              position_next = pend_pos;
            end
            pend_next     = 1'b1;
            pend_key_next = mkey;
            pend_pos_next = k[3:0];
            k_next        = k + KW'(1);
          end
        end
        rd_a = ix_next;
        rd_b = ib_next;
      end
      default: state_next = ssae_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ssae_pkg::S_IDLE;
      ca     <= '0;
      cb     <= '0;
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      ca     <= ca_next;
      cb     <= cb_next;
      strobe <= strobe_next;
      pend   <= pend_next;
    end
    ix       <= ix_next;
    ib       <= ib_next;
    k        <= k_next;
    key      <= key_next;
    sel      <= sel_next;
    tgt      <= tgt_next;
    pend_key <= pend_key_next;
    pend_pos <= pend_pos_next;
    last     <= last_next;
    status   <= status_next;
    element  <= element_next;
    position <= position_next;
  end

`ifndef ASSERT_OFF
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy) else $error("final word while busy");
  a_mid_merge: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (state == ssae_pkg::S_MRG)) else $error("early word outside merge");
  a_count_a: assert property (@(posedge clk) disable iff (rst)
    (ca <= FULL) && (cb <= FULL)) else $error("set count overflow");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == ssae_pkg::OP_REPORT && ca == FULL && cb == FULL) |=> busy)
    else $error("report did not start merge");
`endif

endmodule

>>> tb/small_set_algebra_engine_tb.sv
// Testbench for the small set algebra engine: directed and random words against a behavioral set model.
`timescale 1ns / 100ps
module small_set_algebra_engine_tb;

  localparam int SZ = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    ssae_pkg::status_t status;
    logic [31:0]       element;
    logic [3:0]        position;
    logic              last;
  } result_t;

  logic clk, rst, start, busy, strobe, last;
  logic [1:0] opcode;
  logic signed [31:0] value;
  logic [2:0] list_select, status;
  logic signed [31:0] element;
  logic [3:0] position;

  logic signed [31:0] set_a[$], set_b[$];
  result_t pending[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0;

  small_set_algebra_engine #(.SET_SIZE(SZ)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .value(value), .list_select(list_select), .strobe(strobe), .status(status),
    .element(element), .position(position), .last(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic result_t mk(ssae_pkg::status_t s, logic [31:0] e, logic [3:0] p,
                                 logic l);
    result_t r;
    r.status = s; r.element = e; r.position = p; r.last = l;
    return r;
  endfunction

  function automatic ssae_pkg::status_t insert_value(ref logic signed [31:0] s[$],
                                                     input logic signed [31:0] v);
    int at;
    foreach (s[i]) if (s[i] == v) return ssae_pkg::ST_DUPLICATE;
    if (s.size() >= SZ) return ssae_pkg::ST_FULL;
    at = 0;
    while (at < s.size() && s[at] < v) at++;
    s.insert(at, v);
    return ssae_pkg::ST_ACCEPTED;
  endfunction

  task automatic predict_report(input logic [2:0] sel);
    int i, j, k;
    logic ina, inb;
    logic signed [31:0] key;
    i = 0; j = 0; k = 0;
    if (set_a.size() < SZ || set_b.size() < SZ) begin
      pending.push_back(mk(ssae_pkg::ST_INCOMPLETE, '0, '0, 1'b1));
      return;
    end
    while ((i < SZ || j < SZ) && k < ssae_pkg::MAX_RESULTS) begin
      if (j >= SZ || (i < SZ && set_a[i] < set_b[j])) begin
        ina = 1; inb = 0; key = set_a[i]; i++;
      end else if (i >= SZ || set_b[j] < set_a[i]) begin
        ina = 0; inb = 1; key = set_b[j]; j++;
      end else begin
        ina = 1; inb = 1; key = set_a[i]; i++; j++;
      end
      if (ssae_pkg::selected(sel, ina, inb)) begin
        pending.push_back(mk(ssae_pkg::ST_ELEMENT, key, k[3:0], 1'b0));
        k++;
      end
    end
    if (k == 0) pending.push_back(mk(ssae_pkg::ST_EMPTY, '0, '0, 1'b1));
    else pending[pending.size()-1].last = 1;
  endtask

  task automatic predict_word(ssae_pkg::op_t op, logic signed [31:0] v, logic [2:0] sel);
    case (op)
      ssae_pkg::OP_ADD_A: pending.push_back(mk(insert_value(set_a, v), '0, '0, 1'b1));
      ssae_pkg::OP_ADD_B: pending.push_back(mk(insert_value(set_b, v), '0, '0, 1'b1));
      ssae_pkg::OP_REPORT: predict_report(sel);
      default: begin
        set_a.delete(); set_b.delete();
        pending.push_back(mk(ssae_pkg::ST_ACCEPTED, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
        ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    repeat (g) @(negedge clk);
  endtask

  task automatic send_word(ssae_pkg::op_t op, logic signed [31:0] v, logic [2:0] sel);
    @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1; opcode <= op; value <= v; list_select <= sel;
    @(posedge clk);
    predict_word(op, v, sel);
    sent++;
    @(negedge clk);
    start <= 0;
    opcode <= 2'($urandom); value <= $urandom; list_select <= 3'($urandom);
    random_gap();
  endtask

  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
    repeat (2 * SZ + 4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d element=%0h", status, element);
        errors++;
      end else begin
        result_t e;
        e = pending.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (element !== e.element) begin
          $error("element exp %0h got %0h", e.element, element); errors++;
        end
        if (position !== e.position) begin
          $error("position exp %0d got %0d", e.position, position); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic fill_random(int pool);
    while (set_a.size() < SZ || set_b.size() < SZ) begin
      logic signed [31:0] v;
      v = pool ? $signed($urandom_range(0, pool)) - pool / 2 : $urandom;
      send_word(ssae_pkg::op_t'($urandom_range(0, 1)), v, 3'd0);
    end
  endtask

  task automatic test_directed();
    send_word(ssae_pkg::OP_REPORT, 0, ssae_pkg::LS_A);
    send_word(ssae_pkg::OP_ADD_A, 32'sh7fffffff, 3'd0);
    send_word(ssae_pkg::OP_ADD_A, 32'sh80000000, 3'd0);
    send_word(ssae_pkg::OP_ADD_A, 32'sh7fffffff, 3'd0);
    send_word(ssae_pkg::OP_ADD_B, 32'sh80000000, 3'd0);
    send_word(ssae_pkg::OP_ADD_B, -1, 3'd0);
    for (int i = 0; i < 6; i++) send_word(ssae_pkg::OP_ADD_A, i * 3, 3'd0);
    send_word(ssae_pkg::OP_ADD_A, 99, 3'd0);
    send_word(ssae_pkg::OP_ADD_A, 0, 3'd0);
    for (int i = 0; i < 6; i++) send_word(ssae_pkg::OP_ADD_B, i * 2, 3'd0);
    send_word(ssae_pkg::OP_REPORT, 0, ssae_pkg::LS_UNION);
    send_word(ssae_pkg::OP_REPORT, 0, 3'd7);
    drain();
  endtask

  task automatic test_all_lists();
    for (int s = 0; s < 8; s++) send_word(ssae_pkg::OP_REPORT, 0, s[2:0]);
    send_word(ssae_pkg::OP_CLEAR, 0, 3'd0);
    for (int i = 0; i < SZ; i++) begin
      send_word(ssae_pkg::OP_ADD_A, i, 3'd0);
      send_word(ssae_pkg::OP_ADD_B, i, 3'd0);
    end
    for (int s = 4; s < 7; s++) send_word(ssae_pkg::OP_REPORT, 0, s[2:0]);
    send_word(ssae_pkg::OP_REPORT, 0, ssae_pkg::LS_INTER);
    send_word(ssae_pkg::OP_CLEAR, 0, 3'd0);
    for (int i = 0; i < SZ; i++) begin
      send_word(ssae_pkg::OP_ADD_A, i, 3'd0);
      send_word(ssae_pkg::OP_ADD_B, i + 100, 3'd0);
    end
    send_word(ssae_pkg::OP_REPORT, 0, ssae_pkg::LS_INTER);
    send_word(ssae_pkg::OP_REPORT, 0, ssae_pkg::LS_XOR);
    drain();
  endtask

  task automatic test_random();
    while (sent < 340) begin
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_word(ssae_pkg::op_t'($urandom_range(0, 3)), $urandom, 3'($urandom));
      end else begin
        send_word(ssae_pkg::OP_CLEAR, 0, 3'd0);
        fill_random(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(8, 40));
        repeat ($urandom_range(2, 5)) send_word(ssae_pkg::OP_REPORT, 0, 3'($urandom));
        if (r == 1) drain();
      end
    end
    drain();
  endtask

  initial begin
    rst = 1; start = 0; opcode = 0; value = 0; list_select = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_all_lists();
    test_random();
    if (errors == 0 && pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/ssae_pkg.sv
rtl/core/small_set_algebra_engine.sv
tb/small_set_algebra_engine_tb.sv
